>>> hdl/vgrt_pkg.sv
`default_nettype none
package vgrt_pkg;

  // default for the largest usable grid size per axis
  localparam int MAX_DIM_DEF = 16;

  // field widths
  localparam int ORIGIN_W  = 23;
  localparam int DIR_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int TILE_W    = ORIGIN_W - FRAC_W - 1;
  localparam int CUR_W     = TILE_W + 1;
  localparam int NUM_W     = 25;
  localparam int DEN_W     = DIR_W;
  localparam int PROD_W    = NUM_W + DEN_W + 1;
  localparam int IDX_W     = 12;
  localparam int COORD_W   = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // one cell in Q16 grid units
  localparam logic signed [NUM_W-1:0] ONE_CELL = NUM_W'(1) <<< FRAC_W;

  // grid size reset value
  localparam logic [CFG_W-1:0] GRID_RST = CFG_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_X,
    REG_GRID_Y,
    REG_GRID_Z
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_STEP,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic step;
    logic empty;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_out;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/vgrt_if.sv
`default_nettype none
// ray request channel
interface vgrt_in_if import vgrt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ORIGIN_W-1:0] origin_x;
  logic signed [ORIGIN_W-1:0] origin_y;
  logic signed [ORIGIN_W-1:0] origin_z;
  logic signed [DIR_W-1:0]    dir_x;
  logic signed [DIR_W-1:0]    dir_y;
  logic signed [DIR_W-1:0]    dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

// visited cell channel
interface vgrt_out_if import vgrt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   cell_index;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COORD_W-1:0] cell_z;
  logic               none_inside;
  logic               last;

  modport source (output valid, cell_index, cell_x, cell_y, cell_z, none_inside, last,
                  input ready);
  modport sink   (input valid, cell_index, cell_x, cell_y, cell_z, none_inside, last,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/vgrt_ctrl.sv
`default_nettype none
module vgrt_ctrl import vgrt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = stat.start_out ? ST_OUT : ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_STEP;
      ST_STEP:  state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = stat.last ? ST_IDLE : ST_MUL1;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: cmd.empty = stat.start_out;
      ST_MUL1:  cmd.mul1  = 1'b1;
      ST_MUL2:  cmd.mul2  = 1'b1;
      ST_STEP:  cmd.step  = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/vgrt_dp.sv
`default_nettype none
module vgrt_dp import vgrt_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [CFG_W-1:0]           cfg_data,
  input  wire logic signed [ORIGIN_W-1:0] origin_i [3],
  input  wire logic signed [DIR_W-1:0]    dir_i [3],
  input  wire dp_cmd_t                    cmd,
  output dp_stat_t                        stat,
  output logic [IDX_W-1:0]                cell_index,
  output logic [COORD_W-1:0]              cell_x,
  output logic [COORD_W-1:0]              cell_y,
  output logic [COORD_W-1:0]              cell_z,
  output logic                            none_inside,
  output logic                            last
);

  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int PASS_W     = $clog2(3 * MAX_DIM + 1);
  localparam int GXY_W      = 2 * DIM_W;
  localparam int FULL_IDX_W = (3 * DIM_W > IDX_W) ? 3 * DIM_W : IDX_W;

  logic [CFG_W-1:0]        gcfg_r [3];
  logic [DIM_W-1:0]        g_r [3];
  logic [GXY_W-1:0]        gxy_r;
  logic [PASS_W-1:0]       pass_r;
  logic signed [CUR_W-1:0] cur_r [3];
  logic signed [NUM_W-1:0] num_r [3];
  logic [DEN_W-1:0]        den_r [3];
  logic                    neg_r [3];
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic [1:0]              ax1_r;

  logic [IDX_W-1:0]   idx_r;
  logic [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic               none_r, last_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcfg_r[0] <= GRID_RST;
      gcfg_r[1] <= GRID_RST;
      gcfg_r[2] <= GRID_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRID_X: gcfg_r[0] <= cfg_data;
        REG_GRID_Y: gcfg_r[1] <= cfg_data;
        REG_GRID_Z: gcfg_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ray setup per axis
  logic [DIM_W-1:0]        g_ld [3];
  logic signed [CUR_W-1:0] cur_ld [3];
  logic signed [NUM_W-1:0] num_ld [3];
  logic [DEN_W-1:0]        den_ld [3];

  always_comb begin
    logic [TILE_W-1:0]       tile;
    logic signed [NUM_W-1:0] o_ext, t_ext;
    for (int a = 0; a < 3; a++) begin
      if (gcfg_r[a] == '0) g_ld[a] = DIM_W'(1);
      else if (gcfg_r[a] > CFG_W'(MAX_DIM)) g_ld[a] = DIM_W'(MAX_DIM);
      else g_ld[a] = DIM_W'(gcfg_r[a]);
      tile = origin_i[a][ORIGIN_W-1] ? '0 : origin_i[a][FRAC_W +: TILE_W];
      cur_ld[a] = $signed(CUR_W'(tile));
      o_ext = NUM_W'(origin_i[a]);
      t_ext = $signed(NUM_W'({tile, {FRAC_W{1'b0}}}));
      if (dir_i[a] == '0) num_ld[a] = '0;
      else if (dir_i[a][DIR_W-1]) num_ld[a] = o_ext - t_ext;
      else num_ld[a] = t_ext + ONE_CELL - o_ext;
      den_ld[a] = dir_i[a][DIR_W-1] ? DEN_W'(~dir_i[a] + 1'b1) : DEN_W'(dir_i[a]);
    end
  end

  // start cell outside the grid
  always_comb begin
    stat.start_out = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (cur_r[a] >= $signed(CUR_W'(g_r[a]))) stat.start_out = 1'b1;
    end
    stat.last = last_r;
  end

  // crossing compare helpers
  logic lt_yx, lt_za;
  logic [1:0] ax_fin;
  assign lt_yx = (den_r[1] == '0) ? 1'b0 : (den_r[0] == '0) ? 1'b1 : (pa_r < pb_r);
  assign lt_za = (den_r[2] == '0) ? 1'b0 : (den_r[ax1_r] == '0) ? 1'b1 : (pa_r < pb_r);
  assign ax_fin = lt_za ? 2'd2 : ax1_r;

  logic [1:0] ax1_sel;
  assign ax1_sel = (cmd.mul2 && lt_yx) ? 2'd1 : 2'd0;

  // next cell and exit check
  logic signed [CUR_W-1:0] cur_next [3];
  logic [PASS_W-1:0]       pass_dec;
  logic                    exit_next;

  always_comb begin
    exit_next = 1'b0;
    for (int a = 0; a < 3; a++) begin
      cur_next[a] = cur_r[a];
      if (ax_fin == 2'(a) && den_r[a] != '0) begin
        cur_next[a] = neg_r[a] ? cur_r[a] - 1'b1 : cur_r[a] + 1'b1;
      end
      if (cur_next[a] < 0 || cur_next[a] >= $signed(CUR_W'(g_r[a]))) exit_next = 1'b1;
    end
    pass_dec = pass_r - 1'b1;
  end

  // linear index of the current cell
  logic [FULL_IDX_W-1:0] idx_full;
  assign idx_full = FULL_IDX_W'(cur_r[0][DIM_W-1:0])
                  + FULL_IDX_W'(cur_r[1][DIM_W-1:0]) * FULL_IDX_W'(g_r[0])
                  + FULL_IDX_W'(cur_r[2][DIM_W-1:0]) * FULL_IDX_W'(gxy_r);

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        g_r[a]   <= g_ld[a];
        cur_r[a] <= cur_ld[a];
        num_r[a] <= num_ld[a];
        den_r[a] <= den_ld[a];
        neg_r[a] <= dir_i[a][DIR_W-1];
      end
      gxy_r  <= GXY_W'(g_ld[0]) * GXY_W'(g_ld[1]);
      pass_r <= PASS_W'(g_ld[0]) + PASS_W'(g_ld[1]) + PASS_W'(g_ld[2]);
    end
    if (cmd.mul1) begin
      pa_r <= num_r[1] * $signed({1'b0, den_r[0]});
      pb_r <= num_r[0] * $signed({1'b0, den_r[1]});
    end
    if (cmd.mul2) begin
      ax1_r <= ax1_sel;
      pa_r  <= num_r[2] * $signed({1'b0, den_r[ax1_sel]});
      pb_r  <= num_r[ax1_sel] * $signed({1'b0, den_r[2]});
    end
    if (cmd.step) begin
      for (int a = 0; a < 3; a++) begin
        cur_r[a] <= cur_next[a];
        if (ax_fin == 2'(a) && den_r[a] != '0) num_r[a] <= num_r[a] + ONE_CELL;
      end
      pass_r <= pass_dec;
      idx_r  <= idx_full[IDX_W-1:0];
      cx_r   <= cur_r[0][COORD_W-1:0];
      cy_r   <= cur_r[1][COORD_W-1:0];
      cz_r   <= cur_r[2][COORD_W-1:0];
      none_r <= 1'b0;
      last_r <= (pass_dec == '0) || exit_next;
    end
    if (cmd.empty) begin
      idx_r  <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      cz_r   <= '0;
      none_r <= 1'b1;
      last_r <= 1'b1;
    end
  end

  assign cell_index  = idx_r;
  assign cell_x      = cx_r;
  assign cell_y      = cy_r;
  assign cell_z      = cz_r;
  assign none_inside = none_r;
  assign last        = last_r;

endmodule
`default_nettype wire

>>> hdl/voxel_grid_ray_traversal_top.sv
`default_nettype none
// 3D grid ray walk (Amanatides-Woo). One ray request is taken at a time: in_ch.ready is
// high only while the block is idle. After acceptance the check state tests the start cell;
// then each visited cell passes through the MUL1 and MUL2 cross-multiply compare states,
// which share the pa_r/pb_r product registers, the STEP state and the OUT state, which
// waits while out_ch.ready stays low. A ray visits at most grid_x + grid_y + grid_z cells.
// A start outside the grid gives one result with none_inside set. Grid size writes take
// effect on the next request.
module voxel_grid_ray_traversal_top import vgrt_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data,
  vgrt_in_if.sink                   in_ch,
  vgrt_out_if.source                out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic signed [ORIGIN_W-1:0] origin [3];
  logic signed [DIR_W-1:0]    dir [3];

  assign origin[0] = in_ch.origin_x;
  assign origin[1] = in_ch.origin_y;
  assign origin[2] = in_ch.origin_z;
  assign dir[0]    = in_ch.dir_x;
  assign dir[1]    = in_ch.dir_y;
  assign dir[2]    = in_ch.dir_z;

  vgrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  vgrt_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .origin_i    (origin),
    .dir_i       (dir),
    .cmd         (cmd),
    .stat        (stat),
    .cell_index  (out_ch.cell_index),
    .cell_x      (out_ch.cell_x),
    .cell_y      (out_ch.cell_y),
    .cell_z      (out_ch.cell_z),
    .none_inside (out_ch.none_inside),
    .last        (out_ch.last)
  );

  // an empty result is always the only and last one, with zero cell fields
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.none_inside |-> out_ch.last && out_ch.cell_index == '0)
    else $error("empty result not marked last");

  // no new request while a result is pending
  a_one_ray: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("request taken while result pending");

  // a non-final result is followed by more walking, not a new request
  a_continue: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> !in_ch.ready)
    else $error("run ended before last result");

endmodule
`default_nettype wire

>>> dv/voxel_grid_ray_traversal_top_tb.sv
`timescale 1ns / 100ps
module voxel_grid_ray_traversal_top_tb;
  import vgrt_pkg::*;

  typedef struct packed {
    logic signed [ORIGIN_W-1:0] ox;
    logic signed [ORIGIN_W-1:0] oy;
    logic signed [ORIGIN_W-1:0] oz;
    logic signed [DIR_W-1:0]    dx;
    logic signed [DIR_W-1:0]    dy;
    logic signed [DIR_W-1:0]    dz;
  } ray_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               none;
    logic               last;
  } cell_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  vgrt_in_if  in_ch ();
  vgrt_out_if out_ch ();

  voxel_grid_ray_traversal_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // grid size copy, raw register values
  logic [CFG_W-1:0] grid_reg [3];

  ray_t  rays_pending [$];
  cell_t cells_due [$];
  int    errors = 0;
  int    rays_sent = 0;
  int    cells_seen = 0;
  int    empties_seen = 0;
  bit    quiet = 1'b0;

  // append a ray request to the driver queue
  function automatic void add_ray(ray_t r);
    rays_pending = {rays_pending, r};
  endfunction

  // append an expected cell to the scoreboard
  function automatic void add_cell(cell_t c);
    cells_due = {cells_due, c};
  endfunction

  function automatic longint grid_dim(logic [CFG_W-1:0] r);
    if (r < 1) return 1;
    if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
    return r;
  endfunction

  // walk the grid for one ray and queue every cell it visits
  function automatic void walk_ray(ray_t r);
    longint g[3], cur[3], stp[3], num[3], den[3];
    longint org[3], dir[3];
    longint tile, passes;
    int ax;
    cell_t c;
    cell_t run [$];
    org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
    dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
    for (int a = 0; a < 3; a++) begin
      g[a] = grid_dim(grid_reg[a]);
      tile = (org[a] < 0) ? 0 : (org[a] >>> FRAC_W);
      cur[a] = tile;
      if (dir[a] > 0) begin
        stp[a] = 1; den[a] = dir[a]; num[a] = (tile + 1) * 65536 - org[a];
      end else if (dir[a] < 0) begin
        stp[a] = -1; den[a] = -dir[a]; num[a] = org[a] - tile * 65536;
      end else begin
        stp[a] = 0; den[a] = 0; num[a] = 0;
      end
    end
    // start cell outside the grid: one flagged result
    if (cur[0] >= g[0] || cur[1] >= g[1] || cur[2] >= g[2]) begin
      c = '0;
      c.none = 1'b1;
      c.last = 1'b1;
      add_cell(c);
      return;
    end
    passes = g[0] + g[1] + g[2];
    while (passes > 0) begin
      passes--;
      if (cur[0] < 0 || cur[1] < 0 || cur[2] < 0 ||
          cur[0] >= g[0] || cur[1] >= g[1] || cur[2] >= g[2]) break;
      c.idx  = IDX_W'(cur[0] + cur[1] * g[0] + cur[2] * g[0] * g[1]);
      c.x    = COORD_W'(cur[0]);
      c.y    = COORD_W'(cur[1]);
      c.z    = COORD_W'(cur[2]);
      c.none = 1'b0;
      c.last = 1'b0;
      run = {run, c};
      // earliest crossing wins, ties go x then y then z
      ax = 0;
      if (den[1] != 0 && (den[0] == 0 || num[1] * den[0] < num[0] * den[1])) ax = 1;
      if (den[2] != 0 && (den[ax] == 0 || num[2] * den[ax] < num[ax] * den[2])) ax = 2;
      if (den[ax] != 0) num[ax] += 65536;
      cur[ax] += stp[ax];
    end
    run[run.size()-1].last = 1'b1;
    cells_due = {cells_due, run};
  endfunction

  // request driver
  int gap_left = 0;
  always @(posedge clk) begin
    bit   take;
    ray_t nxt;
    bit   offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      take = in_ch.valid && in_ch.ready;
      if (take) begin
        walk_ray(rays_pending.pop_front());
        rays_sent++;
      end
      // a waiting request stays on the bus until taken
      if (!in_ch.valid || take) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 12) - 1;
        end else if (rays_pending.size() > 0) begin
          offer = 1'b1;
          nxt = rays_pending[0];
        end
        in_ch.valid <= offer;
        if (offer) begin
          in_ch.origin_x <= nxt.ox;
          in_ch.origin_y <= nxt.oy;
          in_ch.origin_z <= nxt.oz;
          in_ch.dir_x    <= nxt.dx;
          in_ch.dir_y    <= nxt.dy;
          in_ch.dir_z    <= nxt.dz;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    cell_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.cell_index, out_ch.cell_x, out_ch.cell_y, out_ch.cell_z,
               out_ch.none_inside, out_ch.last};
        cells_seen++;
        if (got.none) empties_seen++;
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected cell, actual %p", $time, got);
          errors++;
        end else begin
          want = cells_due.pop_front();
          if (got.idx !== want.idx || got.x !== want.x || got.y !== want.y ||
              got.z !== want.z || got.none !== want.none || got.last !== want.last) begin
            $display("%0t: cell differs, expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up its request side
      if (!long_hold_done && cells_seen >= 150) begin
        long_hold_done = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    case (r)
      REG_GRID_X: grid_reg[0] = v;
      REG_GRID_Y: grid_reg[1] = v;
      default:    grid_reg[2] = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (rays_pending.size() != 0 || cells_due.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return -16'sd32768;
      2: return 16'sd32767;
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [ORIGIN_W-1:0] rand_origin(int axis);
    int span;
    span = int'(grid_dim(grid_reg[axis])) * 65536;
    case ($urandom_range(0, 9))
      0: return ORIGIN_W'($urandom);
      1: return ORIGIN_W'($urandom_range(0, span - 1)) - ORIGIN_W'($urandom_range(0, 131072));
      2: return ORIGIN_W'(span + $urandom_range(0, 65535));
      default: return ORIGIN_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.ox = ORIGIN_W'(ox); r.oy = ORIGIN_W'(oy); r.oz = ORIGIN_W'(oz);
    r.dx = DIR_W'(dx);    r.dy = DIR_W'(dy);    r.dz = DIR_W'(dz);
    return r;
  endfunction

  logic [CFG_W-1:0] grid_sets [7][3] = '{
    '{16, 16, 16}, '{1, 1, 1}, '{0, 31, 2}, '{5, 3, 7},
    '{16, 1, 8}, '{3, 16, 16}, '{16, 16, 16}
  };

  initial begin
    ray_t r;
    cfg_we = 1'b0;
    cfg_idx = REG_GRID_X;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    out_ch.ready = 1'b0;
    for (int a = 0; a < 3; a++) grid_reg[a] = GRID_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed rays on the reset grid
    add_ray(mk(0, 0, 0, 32767, 0, 0));
    add_ray(mk(32768, 32768, 32768, 16384, 16384, 16384));  // ties
    add_ray(mk(32768, 32768, 32768, -16384, -16384, -16384));
    add_ray(mk(65536*3, 65536*4, 65536*5, 0, 0, 0));      // no motion
    add_ray(mk(4194303, 4194303, 4194303, -32768, -32768, -32768));
    add_ray(mk(-4194304, -4194304, -4194304, -32768, -32768, -32768));
    add_ray(mk(-4194304, -65536, -1, 32767, 32767, 32767));
    add_ray(mk(1048575, 1048575, 1048575, 32767, 32767, 32767));
    add_ray(mk(1048575, 1048575, 1048575, -32768, -1, -32768));
    add_ray(mk(0, 65536*16, 0, 100, 100, 100));          // y outside
    add_ray(mk(0, 0, 65536*20, 100, 100, 100));          // z outside
    add_ray(mk(65536*16, 0, 0, -100, 100, 100));         // x outside
    add_ray(mk(65536*8, 65536*8, 65536*8, 1, -1, 0));
    add_ray(mk(65536*8, 65536*8, 65536*8, 0, 0, -1));
    add_ray(mk(12345, 99999, 777777, 32767, -32768, 1));
    add_ray(mk(-32768, 5*65536, 7*65536+1, 0, -32768, 32767));

    // phases over grid sizes, extremes and out-of-range values included
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_reg(REG_GRID_X, grid_sets[p][0]);
      write_reg(REG_GRID_Y, grid_sets[p][1]);
      write_reg(REG_GRID_Z, grid_sets[p][2]);
      if (p == 6) quiet = 1'b1;
      for (int i = 0; i < 52; i++) begin
        r.ox = rand_origin(0); r.oy = rand_origin(1); r.oz = rand_origin(2);
        r.dx = rand_dir();     r.dy = rand_dir();     r.dz = rand_dir();
        add_ray(r);
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);
    $display("rays sent %0d, cells checked %0d (%0d outside-grid starts)",
             rays_sent, cells_seen, empties_seen);
    $display("grid sizes from 1 to 16 per axis, including writes of 0 and 31");
    if (errors == 0 && cells_due.size() == 0)
      $display("voxel_grid_ray_traversal_top: match");
    else
      $display("voxel_grid_ray_traversal_top: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("voxel_grid_ray_traversal_top: mismatch");
    $finish;
  end

endmodule
